### rtl/core/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types and constants for the 6502 register/ALU execute block.
// ----------------------------------------------------------------------------
`default_nettype none
package c6502_pkg;
  localparam int unsigned ByteW = 8;
  localparam logic [7:0] SpReset = 8'hFD;
  localparam logic [7:0] PReset  = 8'h24;
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] operand;
  } req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       write_back;
    logic       branch_taken;
    logic       known;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] status_out;
  } res_t;
endpackage
`default_nettype wire

### rtl/core/c6502_if.sv
// ----------------------------------------------------------------------------
// c6502_req_if / c6502_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface c6502_req_if;
  logic              valid;
  logic              ready;
  c6502_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c6502_res_if;
  logic              valid;
  logic              ready;
  c6502_pkg::res_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/cpu6502_register_alu_execute.sv
// ----------------------------------------------------------------------------
// cpu6502_register_alu_execute
// 6502 register/ALU execute stage, binary mode, official and illegal opcodes.
// ----------------------------------------------------------------------------
// One request per cycle unless the output stalls: opcode and operand are
// decoded and executed in a single combinational pass against the
// architectural registers (an 8-bit adder, logic unit and shifter), and the
// result lands in an output register the same edge. The result register is
// refilled as it is taken: one request per clock while the output is ready.
`default_nettype none
module cpu6502_register_alu_execute (
  input  wire logic clk,
  input  wire logic rst_n,
  c6502_req_if.sink   in_ch,
  c6502_res_if.source out_ch
);
  logic [7:0] a_r, x_r, y_r, s_r, p_r;
  logic [7:0] a_nxt, x_nxt, y_nxt, s_nxt, p_nxt;
  logic       vld_r;
  c6502_pkg::res_t res_r, res_nxt;
  logic       acc_fire;

  assign in_ch.ready  = !vld_r || out_ch.ready;
  assign acc_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = vld_r;
  assign out_ch.data  = res_r;

  logic [7:0] op, m, val, sh_in, sh_out, t;
  logic       wb, br, kn, sh_c, sh_left, sh_rot, use_sh, f;
  logic [8:0] sum;
  logic [7:0] add_b;

  always_comb begin
    op = in_ch.data.mode;
    m  = in_ch.data.operand;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; p_nxt = p_r;
    val = 8'h00; wb = 1'b0; br = 1'b0; kn = 1'b1;
    sh_in = m; sh_left = 1'b1; sh_rot = 1'b0; use_sh = 1'b0;
    sh_out = 8'h00; sh_c = 1'b0; sum = 9'h000; add_b = m; t = 8'h00; f = 1'b0;
    case (op)
      8'h09, 8'h05, 8'h15, 8'h01, 8'h11, 8'h0D, 8'h1D, 8'h19: a_nxt = a_r | m;
      8'h29, 8'h25, 8'h35, 8'h21, 8'h31, 8'h2D, 8'h3D, 8'h39: a_nxt = a_r & m;
      8'h49, 8'h45, 8'h55, 8'h41, 8'h51, 8'h4D, 8'h5D, 8'h59: a_nxt = a_r ^ m;
      8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
        sh_in = a_r; sh_left = ~op[6]; sh_rot = op[5]; use_sh = 1'b1;
      end
      8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
      8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E,
      8'h07, 8'h17, 8'h03, 8'h13, 8'h0F, 8'h1F, 8'h1B,
      8'h27, 8'h37, 8'h23, 8'h33, 8'h2F, 8'h3F, 8'h3B,
      8'h47, 8'h57, 8'h43, 8'h53, 8'h4F, 8'h5F, 8'h5B,
      8'h67, 8'h77, 8'h63, 8'h73, 8'h6F, 8'h7F, 8'h7B: begin
        sh_left = ~op[6]; sh_rot = op[5]; use_sh = 1'b1;
      end
      8'h4B: begin
        sh_in = a_r & m; sh_left = 1'b0; use_sh = 1'b1;
      end
      default: ;
    endcase
    if (sh_left) begin
      sh_out = {sh_in[6:0], sh_rot & p_r[c6502_pkg::FlagC]};
      sh_c   = sh_in[7];
    end else begin
      sh_out = {sh_rot & p_r[c6502_pkg::FlagC], sh_in[7:1]};
      sh_c   = sh_in[0];
    end
    // adder operand for ADC/SBC/RRA/ISC
    case (op)
      8'hE9, 8'hE5, 8'hF5, 8'hE1, 8'hF1, 8'hED, 8'hFD, 8'hF9, 8'hEB: add_b = ~m;
      8'hE7, 8'hF7, 8'hE3, 8'hF3, 8'hEF, 8'hFF, 8'hFB: add_b = ~(m + 8'd1);
      8'h67, 8'h77, 8'h63, 8'h73, 8'h6F, 8'h7F, 8'h7B: add_b = sh_out;
      default: add_b = m;
    endcase
    if (op[0] && op[1] && op[6] && op[5] && !op[7]) begin
      p_nxt[c6502_pkg::FlagC] = sh_c;
    end
    sum = {1'b0, a_r} + {1'b0, add_b} +
          {8'h00, (op[0] && op[1] && op[6] && op[5] && !op[7]) ? sh_c
                                                              : p_r[c6502_pkg::FlagC]};
    case (op)
      8'h09, 8'h05, 8'h15, 8'h01, 8'h11, 8'h0D, 8'h1D, 8'h19,
      8'h29, 8'h25, 8'h35, 8'h21, 8'h31, 8'h2D, 8'h3D, 8'h39,
      8'h49, 8'h45, 8'h55, 8'h41, 8'h51, 8'h4D, 8'h5D, 8'h59: begin
        p_nxt[c6502_pkg::FlagN] = a_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (a_nxt == 8'h00);
      end
      8'h69, 8'h65, 8'h75, 8'h61, 8'h71, 8'h6D, 8'h7D, 8'h79,
      8'hE9, 8'hE5, 8'hF5, 8'hE1, 8'hF1, 8'hED, 8'hFD, 8'hF9, 8'hEB,
      8'h67, 8'h77, 8'h63, 8'h73, 8'h6F, 8'h7F, 8'h7B,
      8'hE7, 8'hF7, 8'hE3, 8'hF3, 8'hEF, 8'hFF, 8'hFB: begin
        a_nxt = sum[7:0];
        p_nxt[c6502_pkg::FlagC] = sum[8];
        p_nxt[c6502_pkg::FlagV] = ~(a_r[7] ^ add_b[7]) & (a_r[7] ^ sum[7]);
        p_nxt[c6502_pkg::FlagN] = sum[7]; p_nxt[c6502_pkg::FlagZ] = (sum[7:0] == 8'h00);
        if (op[1] && (op != 8'hEB)) begin
          wb = 1'b1;
          val = op[7] ? m + 8'd1 : sh_out;
        end
      end
      8'hC9, 8'hC5, 8'hD5, 8'hC1, 8'hD1, 8'hCD, 8'hDD, 8'hD9,
      8'hE0, 8'hE4, 8'hEC, 8'hC0, 8'hC4, 8'hCC,
      8'hC7, 8'hD7, 8'hC3, 8'hD3, 8'hCF, 8'hDF, 8'hDB: begin
        t = op[1] ? m - 8'd1 : m;
        if (op[1]) begin
          wb = 1'b1; val = t; f = 1'b0;
        end
        sh_in = (op[1] || op[0]) ? a_r : (op[5] ? x_r : y_r);
        p_nxt[c6502_pkg::FlagC] = (sh_in >= t);
        t = sh_in - t;
        p_nxt[c6502_pkg::FlagN] = t[7]; p_nxt[c6502_pkg::FlagZ] = (t == 8'h00);
      end
      8'hC6, 8'hD6, 8'hCE, 8'hDE, 8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
        val = op[5] ? m + 8'd1 : m - 8'd1; wb = 1'b1;
        p_nxt[c6502_pkg::FlagN] = val[7]; p_nxt[c6502_pkg::FlagZ] = (val == 8'h00);
      end
      8'hCA, 8'hE8: begin
        x_nxt = op[5] ? x_r + 8'd1 : x_r - 8'd1;
        p_nxt[c6502_pkg::FlagN] = x_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (x_nxt == 8'h00);
      end
      8'h88, 8'hC8: begin
        y_nxt = op[6] ? y_r + 8'd1 : y_r - 8'd1;
        p_nxt[c6502_pkg::FlagN] = y_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (y_nxt == 8'h00);
      end
      8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'h4B: begin
        a_nxt = sh_out; p_nxt[c6502_pkg::FlagC] = sh_c;
        p_nxt[c6502_pkg::FlagN] = sh_out[7]; p_nxt[c6502_pkg::FlagZ] = (sh_out == 8'h00);
      end
      8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
      8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
        val = sh_out; wb = 1'b1; p_nxt[c6502_pkg::FlagC] = sh_c;
        p_nxt[c6502_pkg::FlagN] = sh_out[7]; p_nxt[c6502_pkg::FlagZ] = (sh_out == 8'h00);
      end
      8'h07, 8'h17, 8'h03, 8'h13, 8'h0F, 8'h1F, 8'h1B,
      8'h27, 8'h37, 8'h23, 8'h33, 8'h2F, 8'h3F, 8'h3B,
      8'h47, 8'h57, 8'h43, 8'h53, 8'h4F, 8'h5F, 8'h5B: begin
        val = sh_out; wb = 1'b1; p_nxt[c6502_pkg::FlagC] = sh_c;
        case (op[6:5])
          2'b00:   a_nxt = a_r | sh_out;
          2'b01:   a_nxt = a_r & sh_out;
          default: a_nxt = a_r ^ sh_out;
        endcase
        p_nxt[c6502_pkg::FlagN] = a_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (a_nxt == 8'h00);
      end
      8'hA9, 8'hA5, 8'hB5, 8'hA1, 8'hB1, 8'hAD, 8'hBD, 8'hB9, 8'h68: begin
        a_nxt = m;
        if (op == 8'h68) s_nxt = s_r + 8'd1;
        p_nxt[c6502_pkg::FlagN] = m[7]; p_nxt[c6502_pkg::FlagZ] = (m == 8'h00);
      end
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin
        x_nxt = m; p_nxt[c6502_pkg::FlagN] = m[7]; p_nxt[c6502_pkg::FlagZ] = (m == 8'h00);
      end
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin
        y_nxt = m; p_nxt[c6502_pkg::FlagN] = m[7]; p_nxt[c6502_pkg::FlagZ] = (m == 8'h00);
      end
      8'hA7, 8'hB7, 8'hA3, 8'hB3, 8'hAF, 8'hBF, 8'hAB: begin
        a_nxt = m; x_nxt = m;
        p_nxt[c6502_pkg::FlagN] = m[7]; p_nxt[c6502_pkg::FlagZ] = (m == 8'h00);
      end
      8'h85, 8'h95, 8'h81, 8'h91, 8'h8D, 8'h9D, 8'h99: begin
        val = a_r; wb = 1'b1;
      end
      8'h86, 8'h96, 8'h8E, 8'h9E: begin
        val = x_r; wb = 1'b1;
      end
      8'h84, 8'h94, 8'h8C, 8'h9C: begin
        val = y_r; wb = 1'b1;
      end
      8'h87, 8'h97, 8'h83, 8'h8F, 8'h93, 8'h9F: begin
        val = a_r & x_r; wb = 1'b1;
      end
      8'hAA, 8'hBA: begin
        x_nxt = op[4] ? s_r : a_r;
        p_nxt[c6502_pkg::FlagN] = x_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (x_nxt == 8'h00);
      end
      8'hA8: begin
        y_nxt = a_r; p_nxt[c6502_pkg::FlagN] = a_r[7]; p_nxt[c6502_pkg::FlagZ] = (a_r == 8'h00);
      end
      8'h8A, 8'h98: begin
        a_nxt = op[4] ? y_r : x_r;
        p_nxt[c6502_pkg::FlagN] = a_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (a_nxt == 8'h00);
      end
      8'h9A: s_nxt = x_r;
      8'h48: begin
        val = a_r; wb = 1'b1; s_nxt = s_r - 8'd1;
      end
      8'h08: begin
        val = p_r | 8'h30; wb = 1'b1; s_nxt = s_r - 8'd1;
      end
      8'h28: begin
        s_nxt = s_r + 8'd1; p_nxt = (m & 8'hEF) | 8'h20;
      end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
        case (op[7:6])
          2'b00:   f = p_r[c6502_pkg::FlagN];
          2'b01:   f = p_r[c6502_pkg::FlagV];
          2'b10:   f = p_r[c6502_pkg::FlagC];
          default: f = p_r[c6502_pkg::FlagZ];
        endcase
        br = (f == op[5]);
      end
      8'h00, 8'h40, 8'h20, 8'h60, 8'h4C, 8'h6C, 8'hEA: ;
      8'h24, 8'h2C: begin
        p_nxt[c6502_pkg::FlagN] = m[7]; p_nxt[c6502_pkg::FlagV] = m[6];
        p_nxt[c6502_pkg::FlagZ] = ((a_r & m) == 8'h00);
      end
      8'h18, 8'h38: p_nxt[c6502_pkg::FlagC] = op[5];
      8'hD8, 8'hF8: p_nxt[c6502_pkg::FlagD] = op[5];
      8'h58, 8'h78: p_nxt[c6502_pkg::FlagI] = op[5];
      8'hB8: p_nxt[c6502_pkg::FlagV] = 1'b0;
      8'h0B, 8'h2B: begin
        a_nxt = a_r & m; p_nxt[c6502_pkg::FlagC] = a_nxt[7];
        p_nxt[c6502_pkg::FlagN] = a_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (a_nxt == 8'h00);
      end
      8'h6B: begin
        t = a_r & m;
        a_nxt = {p_r[c6502_pkg::FlagC], t[7:1]};
        p_nxt[c6502_pkg::FlagN] = a_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (a_nxt == 8'h00);
        p_nxt[c6502_pkg::FlagC] = a_nxt[6];
        p_nxt[c6502_pkg::FlagV] = a_nxt[6] ^ a_nxt[5];
      end
      8'h8B: begin
        a_nxt = x_r & m;
        p_nxt[c6502_pkg::FlagN] = a_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (a_nxt == 8'h00);
      end
      8'hCB: begin
        t = a_r & x_r;
        p_nxt[c6502_pkg::FlagC] = (t >= m);
        x_nxt = t - m;
        p_nxt[c6502_pkg::FlagN] = x_nxt[7]; p_nxt[c6502_pkg::FlagZ] = (x_nxt == 8'h00);
      end
      8'h9B: begin
        s_nxt = a_r & x_r; val = a_r & x_r; wb = 1'b1;
      end
      8'hBB: begin
        t = m & s_r; a_nxt = t; x_nxt = t; s_nxt = t;
        p_nxt[c6502_pkg::FlagN] = t[7]; p_nxt[c6502_pkg::FlagZ] = (t == 8'h00);
      end
      default: begin
        kn = 1'b0; p_nxt = p_r; a_nxt = a_r;
      end
    endcase
    res_nxt.value = val;
    res_nxt.write_back = wb;
    res_nxt.branch_taken = br;
    res_nxt.known = kn;
    res_nxt.acc_out = a_nxt;
    res_nxt.x_out = x_nxt;
    res_nxt.y_out = y_nxt;
    res_nxt.sp_out = s_nxt;
    res_nxt.status_out = p_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00;
      s_r <= c6502_pkg::SpReset; p_r <= c6502_pkg::PReset;
      vld_r <= 1'b0;
    end else begin
      if (acc_fire) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; p_r <= p_nxt;
        vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) res_r <= res_nxt;
  end

  a_u_bit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> res_r.status_out[c6502_pkg::FlagU]) else $error("status bit 5 clear");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc_fire |=> $stable(a_r) && $stable(s_r) && $stable(p_r))
    else $error("registers changed without a request");
  a_state: assert property (@(posedge clk) disable iff (!rst_n)
    acc_fire |=> res_r.acc_out == a_r && res_r.sp_out == s_r && res_r.status_out == p_r)
    else $error("result and state disagree");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !res_r.write_back |-> res_r.value == 8'h00) else $error("stray value");
endmodule
`default_nettype wire
